// ===== rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for the concurrent assertions of the projector.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define PPP_ASSERT(name, clk, rst_n, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define PPP_ASSERT_ALWAYS(name, clk, prop, msg) \
	name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/ppp_pkg.sv =====
// ---------------------------------------------------------------------------
// ppp_pkg
// Types and constants shared by the perspective point projector.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package ppp_pkg;

	localparam int COEF_FRAC = 24;
	localparam int CLIP_W    = 42;
	localparam int NUM_W     = 57;
	localparam int MAG_W     = 56;
	localparam int DIV_W     = 42;
	localparam int QUOT_W    = 40;
	localparam int TERM_W    = QUOT_W + 2;
	localparam int SUM_W     = TERM_W + 2;
	localparam int SCR_W     = 14;
	localparam int ADDR_W    = 6;

	typedef enum logic [2:0] {
		REG_X_LO  = 3'd0,
		REG_X_HI  = 3'd1,
		REG_Y_LO  = 3'd2,
		REG_Y_HI  = 3'd3,
		REG_W_LO  = 3'd4,
		REG_W_HI  = 3'd5,
		REG_SCR_W = 3'd6,
		REG_SCR_H = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic [2:0][3:0][31:0] coef;
		logic [SCR_W-1:0]      scr_w;
		logic [SCR_W-1:0]      scr_h;
	} cfg_t;

	typedef struct packed {
		logic vis;
		logic neg_x;
		logic neg_y;
	} side_t;

	function automatic logic signed [31:0] sat32(input logic signed [SUM_W-1:0] v);
		logic [SUM_W-32:0] top;
		top = v[SUM_W-1:31];
		if (top == '0 || top == '1) begin
			return v[31:0];
		end
		return v[SUM_W-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
	endfunction

endpackage

// ===== rtl/ppp_cfg.sv =====
// ---------------------------------------------------------------------------
// ppp_cfg
// APB register file holding the matrix columns and the viewport size.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ppp_cfg import ppp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [63:0]       pwdata,
	output logic [63:0]       prdata,
	output cfg_t              cfg
);

	logic [2:0][3:0][31:0] coef_q;
	logic [SCR_W-1:0]      scr_w_q;
	logic [SCR_W-1:0]      scr_h_q;
	reg_idx_t              idx;

	assign idx = reg_idx_t'(paddr[ADDR_W-1:3]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q  <= '0;
			scr_w_q <= SCR_W'(1920);
			scr_h_q <= SCR_W'(1080);
		end else if (psel && penable && pwrite) begin
			unique case (idx)
				REG_X_LO:  coef_q[0][1:0] <= pwdata;
				REG_X_HI:  coef_q[0][3:2] <= pwdata;
				REG_Y_LO:  coef_q[1][1:0] <= pwdata;
				REG_Y_HI:  coef_q[1][3:2] <= pwdata;
				REG_W_LO:  coef_q[2][1:0] <= pwdata;
				REG_W_HI:  coef_q[2][3:2] <= pwdata;
				REG_SCR_W: scr_w_q <= pwdata[SCR_W-1:0];
				REG_SCR_H: scr_h_q <= pwdata[SCR_W-1:0];
				default:   coef_q <= coef_q;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_X_LO:  prdata = coef_q[0][1:0];
			REG_X_HI:  prdata = coef_q[0][3:2];
			REG_Y_LO:  prdata = coef_q[1][1:0];
			REG_Y_HI:  prdata = coef_q[1][3:2];
			REG_W_LO:  prdata = coef_q[2][1:0];
			REG_W_HI:  prdata = coef_q[2][3:2];
			REG_SCR_W: prdata = 64'(scr_w_q);
			REG_SCR_H: prdata = 64'(scr_h_q);
			default:   prdata = '0;
		endcase
	end

	assign cfg.coef  = coef_q;
	assign cfg.scr_w = scr_w_q;
	assign cfg.scr_h = scr_h_q;

endmodule

// ===== rtl/ppp_transform.sv =====
// ---------------------------------------------------------------------------
// ppp_transform
// Two-stage matrix multiply giving clip x, y and w of one point.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ppp_transform import ppp_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  cfg_t                     cfg,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic signed [31:0]       point_x,
	input  logic signed [31:0]       point_y,
	input  logic signed [31:0]       point_z,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic signed [CLIP_W-1:0] clip_x,
	output logic signed [CLIP_W-1:0] clip_y,
	output logic signed [CLIP_W-1:0] clip_w
);

	logic                     v_s1, v_s2, en1, en2;
	logic signed [31:0]       pt [3];
	logic signed [63:0]       prod_s1 [3][3];
	logic signed [31:0]       cterm_s1 [3];
	logic signed [CLIP_W-1:0] sum [3];
	logic signed [CLIP_W-1:0] clip_s2 [3];

	assign pt[0] = point_x;
	assign pt[1] = point_y;
	assign pt[2] = point_z;

	assign en2      = !v_s2 || out_ready;
	assign en1      = !v_s1 || en2;
	assign in_ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (en2) v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			for (int c = 0; c < 3; c++) begin
				for (int r = 0; r < 3; r++) begin
					prod_s1[c][r] <= signed'(cfg.coef[c][r]) * pt[r];
				end
				cterm_s1[c] <= signed'(cfg.coef[c][3]) >>> (COEF_FRAC - FRAC_BITS);
			end
		end
	end

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			sum[c] = CLIP_W'(prod_s1[c][0] >>> COEF_FRAC)
				+ CLIP_W'(prod_s1[c][1] >>> COEF_FRAC)
				+ CLIP_W'(prod_s1[c][2] >>> COEF_FRAC)
				+ CLIP_W'(cterm_s1[c]);
		end
	end

	always_ff @(posedge clk) begin
		if (en2) begin
			for (int c = 0; c < 3; c++) begin
				clip_s2[c] <= sum[c];
			end
		end
	end

	assign out_valid = v_s2;
	assign clip_x    = clip_s2[0];
	assign clip_y    = clip_s2[1];
	assign clip_w    = clip_s2[2];

endmodule

// ===== rtl/ppp_div.sv =====
// ---------------------------------------------------------------------------
// ppp_div
// Two-lane restoring divider with a shared divisor, one quotient bit per
// stage, giving mag * 2^FRAC_BITS / d with an overflow flag per lane.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ppp_div import ppp_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [MAG_W-1:0]  mag_x,
	input  logic [MAG_W-1:0]  mag_y,
	input  logic [DIV_W-1:0]  d,
	input  side_t             side_in,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [QUOT_W-1:0] quot_x,
	output logic [QUOT_W-1:0] quot_y,
	output logic              ovf_x,
	output logic              ovf_y,
	output side_t             side_out
);

	localparam int SH    = QUOT_W - FRAC_BITS;
	localparam int CMP_W = DIV_W + SH;
	localparam int N_W   = MAG_W + FRAC_BITS;

	logic [QUOT_W:0]   v_s;
	logic [QUOT_W:0]   en;
	logic [DIV_W-1:0]  rem_x_s [0:QUOT_W];
	logic [DIV_W-1:0]  rem_y_s [0:QUOT_W];
	logic [QUOT_W-1:0] lo_x_s  [0:QUOT_W];
	logic [QUOT_W-1:0] lo_y_s  [0:QUOT_W];
	logic [QUOT_W-1:0] q_x_s   [0:QUOT_W];
	logic [QUOT_W-1:0] q_y_s   [0:QUOT_W];
	logic [DIV_W-1:0]  d_s     [0:QUOT_W];
	side_t             side_s  [0:QUOT_W];
	logic              ovf_x_s [0:QUOT_W];
	logic              ovf_y_s [0:QUOT_W];
	logic [N_W-1:0]    n_x, n_y;
	logic [CMP_W-1:0]  d_big;

	assign n_x   = {mag_x, {FRAC_BITS{1'b0}}};
	assign n_y   = {mag_y, {FRAC_BITS{1'b0}}};
	assign d_big = {d, {SH{1'b0}}};

	assign en[QUOT_W] = !v_s[QUOT_W] || out_ready;
	assign in_ready   = en[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (en[0]) begin
			v_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			rem_x_s[0] <= DIV_W'(n_x[N_W-1:QUOT_W]);
			rem_y_s[0] <= DIV_W'(n_y[N_W-1:QUOT_W]);
			lo_x_s[0]  <= n_x[QUOT_W-1:0];
			lo_y_s[0]  <= n_y[QUOT_W-1:0];
			q_x_s[0]   <= '0;
			q_y_s[0]   <= '0;
			d_s[0]     <= d;
			side_s[0]  <= side_in;
			ovf_x_s[0] <= CMP_W'(mag_x) >= d_big;
			ovf_y_s[0] <= CMP_W'(mag_y) >= d_big;
		end
	end

	for (genvar k = 0; k < QUOT_W; k++) begin : g_ready
		assign en[k] = !v_s[k] || en[k+1];
	end

	for (genvar k = 1; k <= QUOT_W; k++) begin : g_stage
		logic [DIV_W:0] try_x, try_y;
		logic           ge_x, ge_y;

		assign try_x = {rem_x_s[k-1], lo_x_s[k-1][QUOT_W-1]};
		assign try_y = {rem_y_s[k-1], lo_y_s[k-1][QUOT_W-1]};
		assign ge_x  = try_x >= {1'b0, d_s[k-1]};
		assign ge_y  = try_y >= {1'b0, d_s[k-1]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en[k]) begin
				v_s[k] <= v_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en[k]) begin
				rem_x_s[k] <= ge_x ? DIV_W'(try_x - {1'b0, d_s[k-1]}) : try_x[DIV_W-1:0];
				rem_y_s[k] <= ge_y ? DIV_W'(try_y - {1'b0, d_s[k-1]}) : try_y[DIV_W-1:0];
				lo_x_s[k]  <= {lo_x_s[k-1][QUOT_W-2:0], 1'b0};
				lo_y_s[k]  <= {lo_y_s[k-1][QUOT_W-2:0], 1'b0};
				q_x_s[k]   <= {q_x_s[k-1][QUOT_W-2:0], ge_x};
				q_y_s[k]   <= {q_y_s[k-1][QUOT_W-2:0], ge_y};
				d_s[k]     <= d_s[k-1];
				side_s[k]  <= side_s[k-1];
				ovf_x_s[k] <= ovf_x_s[k-1];
				ovf_y_s[k] <= ovf_y_s[k-1];
			end
		end
	end

	assign out_valid = v_s[QUOT_W];
	assign quot_x    = q_x_s[QUOT_W];
	assign quot_y    = q_y_s[QUOT_W];
	assign ovf_x     = ovf_x_s[QUOT_W];
	assign ovf_y     = ovf_y_s[QUOT_W];
	assign side_out  = side_s[QUOT_W];

endmodule

// ===== rtl/perspective_point_projector.sv =====
// ---------------------------------------------------------------------------
// perspective_point_projector
// Projects 3-D points through a view-projection matrix onto the viewport.
// ---------------------------------------------------------------------------
// The block accepts one point word per cycle while in_ready is high and
// returns one result word per point, in order. A point passes through the
// matrix multiply and sum, the viewport scaling and sign split, the divider
// that forms one quotient bit per stage, and the output register. The divider
// depth sets the latency; throughput is one point per cycle when the output
// is not stalled.
`timescale 1ns / 1ps

module perspective_point_projector import ppp_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [63:0]       pwdata,
	output logic [63:0]       prdata,
	output logic              pready,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic signed [31:0] point_x,
	input  logic signed [31:0] point_y,
	input  logic signed [31:0] point_z,
	output logic              out_valid,
	input  logic              out_ready,
	output logic              visible,
	output logic signed [31:0] screen_x,
	output logic signed [31:0] screen_y
);

	localparam int W_MIN = ((1 << FRAC_BITS) + 50) / 100;

	cfg_t                     cfg;
	logic                     tf_valid, tf_ready;
	logic signed [CLIP_W-1:0] clip_x, clip_y, clip_w;
	logic                     v_s3, v_s4, en3, en4;
	logic signed [NUM_W-1:0]  num_x_s3, num_y_s3;
	logic [DIV_W-1:0]         d_s3, d_s4;
	logic                     vis_s3;
	logic [MAG_W-1:0]         mag_x_s4, mag_y_s4;
	side_t                    side_s4;
	logic                     dv_ready, dv_valid, en_o;
	logic [QUOT_W-1:0]        quot_x, quot_y;
	logic                     ovf_x, ovf_y;
	side_t                    dv_side;
	logic [QUOT_W:0]          tmag_x, tmag_y;
	logic signed [TERM_W-1:0] term_x, term_y;
	logic signed [SUM_W-1:0]  off_x, off_y, sum_x, sum_y;
	logic                     out_valid_q, visible_q;
	logic signed [31:0]       screen_x_q, screen_y_q;

	assign pready = 1'b1;

	ppp_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	ppp_transform #(.FRAC_BITS(FRAC_BITS)) u_tf (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.point_x   (point_x),
		.point_y   (point_y),
		.point_z   (point_z),
		.out_valid (tf_valid),
		.out_ready (tf_ready),
		.clip_x    (clip_x),
		.clip_y    (clip_y),
		.clip_w    (clip_w)
	);

	assign en4      = !v_s4 || dv_ready;
	assign en3      = !v_s3 || en4;
	assign tf_ready = en3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en3) v_s3 <= tf_valid;
			if (en4) v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en3) begin
			num_x_s3 <= NUM_W'(clip_x) * NUM_W'(signed'({1'b0, cfg.scr_w}));
			num_y_s3 <= NUM_W'(clip_y) * NUM_W'(signed'({1'b0, cfg.scr_h}));
			d_s3     <= {clip_w[DIV_W-2:0], 1'b0};
			vis_s3   <= clip_w >= CLIP_W'(W_MIN);
		end
		if (en4) begin
			mag_x_s4      <= MAG_W'(num_x_s3[NUM_W-1] ? -num_x_s3 : num_x_s3);
			mag_y_s4      <= MAG_W'(num_y_s3[NUM_W-1] ? -num_y_s3 : num_y_s3);
			side_s4.vis   <= vis_s3;
			side_s4.neg_x <= num_x_s3[NUM_W-1];
			side_s4.neg_y <= num_y_s3[NUM_W-1];
			d_s4          <= d_s3;
		end
	end

	ppp_div #(.FRAC_BITS(FRAC_BITS)) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s4),
		.in_ready  (dv_ready),
		.mag_x     (mag_x_s4),
		.mag_y     (mag_y_s4),
		.d         (d_s4),
		.side_in   (side_s4),
		.out_valid (dv_valid),
		.out_ready (en_o),
		.quot_x    (quot_x),
		.quot_y    (quot_y),
		.ovf_x     (ovf_x),
		.ovf_y     (ovf_y),
		.side_out  (dv_side)
	);

	assign tmag_x = ovf_x ? {1'b1, {QUOT_W{1'b0}}} : {1'b0, quot_x};
	assign tmag_y = ovf_y ? {1'b1, {QUOT_W{1'b0}}} : {1'b0, quot_y};
	assign term_x = dv_side.neg_x ? -signed'({1'b0, tmag_x}) : signed'({1'b0, tmag_x});
	assign term_y = dv_side.neg_y ? -signed'({1'b0, tmag_y}) : signed'({1'b0, tmag_y});

	assign off_x = SUM_W'(signed'({2'b00, cfg.scr_w}) + 16'sd1) <<< (FRAC_BITS - 1);
	assign off_y = SUM_W'(signed'({2'b00, cfg.scr_h}) - 16'sd1) <<< (FRAC_BITS - 1);
	assign sum_x = off_x + SUM_W'(term_x);
	assign sum_y = off_y - SUM_W'(term_y);

	assign en_o = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en_o) begin
			out_valid_q <= dv_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_o) begin
			visible_q  <= dv_side.vis;
			screen_x_q <= dv_side.vis ? sat32(sum_x) : '0;
			screen_y_q <= dv_side.vis ? sat32(sum_y) : '0;
		end
	end

	assign out_valid = out_valid_q;
	assign visible   = visible_q;
	assign screen_x  = screen_x_q;
	assign screen_y  = screen_y_q;

endmodule

// ===== rtl/ppp_checker.sv =====
// ---------------------------------------------------------------------------
// ppp_checker
// Port-level checks of the projector, bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ppp_checker import ppp_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              psel,
	input logic              penable,
	input logic              pwrite,
	input logic [ADDR_W-1:0] paddr,
	input logic [63:0]       pwdata,
	input logic [63:0]       prdata,
	input logic              pready,
	input logic              out_valid,
	input logic              out_ready,
	input logic              visible,
	input logic signed [31:0] screen_x,
	input logic signed [31:0] screen_y
);

	`PPP_ASSERT(a_out_hold, clk, arst_n, out_valid && !out_ready |=> out_valid && $stable(visible) && $stable(screen_x) && $stable(screen_y), "Stalled result word changed")
	`PPP_ASSERT(a_hidden_zero, clk, arst_n, out_valid && !visible |-> screen_x == 0 && screen_y == 0, "Hidden point has nonzero coordinates")
	`PPP_ASSERT(a_width_readback, clk, arst_n, (psel && penable && pwrite && paddr == {REG_SCR_W, 3'b000}) ##1 (psel && !pwrite && paddr == {REG_SCR_W, 3'b000}) |-> prdata[13:0] == $past(pwdata[13:0]) && prdata[63:14] == 0, "Screen width readback mismatch")
	`PPP_ASSERT_ALWAYS(a_pready, clk, pready, "Register port not ready")

endmodule

bind perspective_point_projector ppp_checker u_ppp_checker (.*);

// ===== bench/perspective_point_projector_checker.sv =====
// ---------------------------------------------------------------------------
// perspective_point_projector_checker
// Follows the register writes and both word channels of the projector. Each
// accepted point gets a predicted screen position, which is queued and
// compared field by field with the result words, in order.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module perspective_point_projector_checker import ppp_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic               pready,
	input  logic [ADDR_W-1:0]  paddr,
	input  logic [63:0]        pwdata,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic signed [31:0] point_x,
	input  logic signed [31:0] point_y,
	input  logic signed [31:0] point_z,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic               visible,
	input  logic signed [31:0] screen_x,
	input  logic signed [31:0] screen_y,
	output int                 mismatches,
	output int                 pending
);

	localparam int     FRAC   = 16;
	localparam longint MIN_W  = ((64'sd1 << FRAC) + 50) / 100;
	localparam longint CAP    = 64'sd1 << 40;

	typedef struct {
		logic              vis;
		logic signed [31:0] sx;
		logic signed [31:0] sy;
	} screen_pos_t;

	logic [63:0] regs [0:7];
	screen_pos_t expected_pos[$];

	function automatic longint coef_of(int col, int row);
		logic [63:0]        r;
		logic signed [31:0] c;
		r = regs[col * 2 + row / 2];
		c = (row % 2 == 1) ? r[63:32] : r[31:0];
		return longint'(c);
	endfunction

	function automatic longint clip_coord(int col, longint px, longint py, longint pz);
		longint s;
		s = (coef_of(col, 0) * px) >>> COEF_FRAC;
		s += (coef_of(col, 1) * py) >>> COEF_FRAC;
		s += (coef_of(col, 2) * pz) >>> COEF_FRAC;
		s += coef_of(col, 3) >>> (COEF_FRAC - FRAC);
		return s;
	endfunction

	function automatic longint scaled_quotient(longint num, longint den);
		logic        neg;
		logic [63:0] mag, d, q, r;
		longint      res;
		neg = num < 0;
		mag = neg ? -num : num;
		d   = den;
		q   = mag / d;
		r   = mag % d;
		if (q >= (64'd1 << (40 - FRAC))) begin
			res = CAP;
		end else begin
			for (int i = 0; i < FRAC; i++) begin
				r = r << 1;
				q = q << 1;
				if (r >= d) begin
					r = r - d;
					q[0] = 1'b1;
				end
			end
			res = q;
		end
		return neg ? -res : res;
	endfunction

	function automatic logic signed [31:0] clamp32(longint v);
		if (v > 64'sd2147483647)
			return 32'sh7FFF_FFFF;
		if (v < -64'sd2147483648)
			return 32'sh8000_0000;
		return v[31:0];
	endfunction

	function automatic screen_pos_t project_point(longint px, longint py, longint pz);
		screen_pos_t p;
		longint      cw, cx, cy, sw, sh, half;
		cw   = clip_coord(2, px, py, pz);
		sw   = regs[REG_SCR_W];
		sh   = regs[REG_SCR_H];
		half = 64'sd1 << (FRAC - 1);
		p.vis = 1'b0;
		p.sx  = '0;
		p.sy  = '0;
		if (cw >= MIN_W) begin
			cx    = clip_coord(0, px, py, pz);
			cy    = clip_coord(1, px, py, pz);
			p.vis = 1'b1;
			p.sx  = clamp32((sw + 1) * half + scaled_quotient(cx * sw, 2 * cw));
			p.sy  = clamp32((sh - 1) * half - scaled_quotient(cy * sh, 2 * cw));
		end
		return p;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++)
				regs[i] = '0;
			regs[REG_SCR_W] = 64'd1920;
			regs[REG_SCR_H] = 64'd1080;
			expected_pos.delete();
			mismatches = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				if (paddr[5:3] >= REG_SCR_W)
					regs[paddr[5:3]] = pwdata & 64'h3FFF;
				else
					regs[paddr[5:3]] = pwdata;
			end
			if (out_valid && out_ready) begin
				if (expected_pos.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("Unexpected result word: visible %0b x %0d y %0d",
							visible, screen_x, screen_y);
				end else begin
					screen_pos_t e;
					e = expected_pos.pop_front();
					if (e.vis !== visible || e.sx !== screen_x || e.sy !== screen_y) begin
						mismatches++;
						if (mismatches <= 10)
							$display("Mismatch: expected %0b %0d %0d, got %0b %0d %0d",
								e.vis, e.sx, e.sy, visible, screen_x, screen_y);
					end
				end
			end
			if (in_valid && in_ready)
				expected_pos.push_back(project_point(longint'(point_x),
					longint'(point_y), longint'(point_z)));
		end
		pending = expected_pos.size();
	end

endmodule

// ===== bench/perspective_point_projector_tb.sv =====
// ---------------------------------------------------------------------------
// perspective_point_projector_tb
// Drives registers and point words into the projector: directed corner points
// under the reset and a plain matrix, then random matrices, screen sizes and
// points under three idling patterns. A checker beside it judges each result.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module perspective_point_projector_tb import ppp_pkg::*;;

	localparam logic [31:0] ONE_COEF = 32'h0100_0000;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [ADDR_W-1:0]  paddr = '0;
	logic [63:0]        pwdata = '0;
	logic [63:0]        prdata;
	logic               pready;
	logic               in_valid = 1'b0, in_ready;
	logic signed [31:0] point_x = '0, point_y = '0, point_z = '0;
	logic               out_valid, out_ready = 1'b0;
	logic               visible;
	logic signed [31:0] screen_x, screen_y;
	int                 mismatches, pending;
	int                 send_gap_pct = 0, recv_stall_pct = 0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	perspective_point_projector u_top (.*);

	perspective_point_projector_checker u_check (.*);

	always @(posedge clk)
		out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);

	task automatic write_reg(reg_idx_t idx, logic [63:0] value);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 3'b000};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
		if ($urandom_range(0, 99) < send_gap_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < send_gap_pct);
		end
		in_valid <= 1'b1;
		point_x  <= x;
		point_y  <= y;
		point_z  <= z;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic drain;
		in_valid <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		repeat (60) @(posedge clk);
	endtask

	function automatic logic [31:0] rand_coef();
		case ($urandom_range(0, 4))
			0: return $urandom;
			1: return $urandom_range(0, 32'h0400_0000) - 32'h0200_0000;
			2: return '0;
			3: return ONE_COEF;
			default: return -ONE_COEF;
		endcase
	endfunction

	function automatic logic [31:0] rand_coord();
		case ($urandom_range(0, 3))
			0: return $urandom;
			1: return $urandom_range(0, 32'h0080_0000) - 32'h0040_0000;
			2: return $urandom_range(0, 32'h0800_0000);
			default: return $urandom_range(0, 32'h0000_4000) - 32'h0000_2000;
		endcase
	endfunction

	function automatic logic [63:0] rand_screen();
		case ($urandom_range(0, 5))
			0: return 64'd8192;
			1: return 64'd1;
			2: return 64'd0;
			3: return {$urandom, $urandom};
			default: return $urandom_range(1, 8192);
		endcase
	endfunction

	task automatic load_random_matrix();
		logic [31:0] w_const;
		w_const = ($urandom_range(0, 3) == 0) ? rand_coef() : $urandom_range(1 << 10, 1 << 28);
		write_reg(REG_X_LO, {rand_coef(), rand_coef()});
		write_reg(REG_X_HI, {rand_coef(), rand_coef()});
		write_reg(REG_Y_LO, {rand_coef(), rand_coef()});
		write_reg(REG_Y_HI, {rand_coef(), rand_coef()});
		write_reg(REG_W_LO, {rand_coef(), rand_coef()});
		write_reg(REG_W_HI, {w_const, rand_coef()});
		write_reg(REG_SCR_W, rand_screen());
		write_reg(REG_SCR_H, rand_screen());
	endtask

	initial begin
		#2000000;
		$display("CHECK FAILED");
		$finish;
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// A point under the reset matrix, which is all zero and so never visible.
		send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000);
		drain();

		// Plain matrix: clip x, y and w are the point's x, y and z.
		write_reg(REG_X_LO, {32'h0, ONE_COEF});
		write_reg(REG_X_HI, 64'h0);
		write_reg(REG_Y_LO, {ONE_COEF, 32'h0});
		write_reg(REG_Y_HI, 64'h0);
		write_reg(REG_W_LO, 64'h0);
		write_reg(REG_W_HI, {32'h0, ONE_COEF});
		send_point(32'h0, 32'h0, 32'h0001_0000);
		send_point(32'h0000_8000, 32'hFFFF_8000, 32'h0001_0000);
		send_point(32'h0, 32'h0, 32'd655);
		send_point(32'h0001_0000, 32'h0001_0000, 32'd654);
		send_point(32'h0, 32'h0, 32'h8000_0000);
		send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd655);
		send_point(32'h8000_0000, 32'h8000_0000, 32'd655);
		send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
		send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		send_point(32'h0010_0000, 32'hFFF0_0000, 32'h0002_0000);
		send_point(32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_0003);
		drain();
		write_reg(REG_SCR_W, 64'd8192);
		write_reg(REG_SCR_H, 64'd8192);
		send_point(32'h0000_FFFF, 32'hFFFF_0001, 32'h0001_0000);
		send_point(32'h0003_0000, 32'hFFFD_0000, 32'h0001_0000);
		drain();
		write_reg(REG_SCR_W, 64'd0);
		write_reg(REG_SCR_H, 64'hFFFF_FFFF_FFFF_C001);
		send_point(32'h0005_0000, 32'h0005_0000, 32'h0001_0000);
		send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'd700);
		drain();

		for (int phase = 0; phase < 3; phase++) begin
			send_gap_pct   = (phase == 0) ? 14 : (phase == 1) ? 80 : 0;
			recv_stall_pct = (phase == 0) ? 80 : (phase == 1) ? 14 : 0;
			for (int round = 0; round < 3; round++) begin
				load_random_matrix();
				for (int n = 0; n < 82; n++)
					send_point(rand_coord(), rand_coord(), rand_coord());
				drain();
			end
		end

		if (mismatches == 0 && pending == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/ppp_pkg.sv
rtl/ppp_cfg.sv
rtl/ppp_transform.sv
rtl/ppp_div.sv
rtl/perspective_point_projector.sv
rtl/ppp_checker.sv
bench/perspective_point_projector_checker.sv
bench/perspective_point_projector_tb.sv
